>>> design/dsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types and constants of the YYYY-MM-DD date string checker.
// ----------------------------------------------------------------------------
package dsv_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned NUM_W    = 7;
	localparam int unsigned LIMIT_W  = 5;

	localparam logic [POS_W-1:0]  DATE_LEN  = 4'd10;
	localparam logic [POS_W-1:0]  LAST_POS  = 4'd9;
	localparam logic [POS_W-1:0]  POS_MAX   = 4'd15;
	localparam logic [POS_W-1:0]  DASH_POS0 = 4'd4;
	localparam logic [POS_W-1:0]  DASH_POS1 = 4'd7;
	localparam logic [CHAR_W-1:0] DASH_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;
	localparam logic [CHAR_W-1:0] NINE_CHAR = 8'h39;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_LENGTH = 3'd1,
		ERR_DASH   = 3'd2,
		ERR_DIGIT  = 3'd3,
		ERR_MONTH  = 3'd4,
		ERR_DAY    = 3'd5
	} error_kind_t;

	// Updated scan state for the item held in the input stage.
	typedef struct packed {
		logic              item_valid;
		logic              last;
		logic              length_ok;
		logic              err_seen;
		error_kind_t       err_kind;
		logic [POS_W-1:0]  err_index;
		logic [CHAR_W-1:0] err_byte;
		logic [NUM_W-1:0]  year;
		logic [NUM_W-1:0]  month;
		logic [NUM_W-1:0]  day;
	} scan_t;

endpackage
`default_nettype wire

>>> design/dsv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_char_if / dsv_result_if
// Valid/ready channels for input characters and for verdicts.
// ----------------------------------------------------------------------------
interface dsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       final_char;

	modport source (output valid, output char_code, output final_char, input ready);
	modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface dsv_result_if;
	logic       valid;
	logic       ready;
	logic       is_valid;
	logic [2:0] error_kind;
	logic [3:0] error_index;
	logic [7:0] bad_character;
	logic [6:0] bad_number;
	logic [4:0] day_limit;

	modport source (output valid, output is_valid, output error_kind, output error_index,
		output bad_character, output bad_number, output day_limit, input ready);
	modport sink   (input valid, input is_valid, input error_kind, input error_index,
		input bad_character, input bad_number, input day_limit, output ready);
endinterface
`default_nettype wire

>>> design/dsv_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_scan
// Input register and per-string scan state: position, first character
// error, and the parsed month, day and last two year digits.
// ----------------------------------------------------------------------------
module dsv_scan
	import dsv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	dsv_char_if.sink   chars,
	input  wire logic  out_busy,
	output scan_t      scan
);

	logic [CHAR_W-1:0] char_s1;
	logic              final_s1;
	logic              valid_s1;

	logic [POS_W-1:0]  pos_q;
	logic              err_seen_q;
	error_kind_t       err_kind_q;
	logic [POS_W-1:0]  err_index_q;
	logic [CHAR_W-1:0] err_byte_q;
	logic [NUM_W-1:0]  year_q;
	logic [NUM_W-1:0]  month_q;
	logic [NUM_W-1:0]  day_q;

	logic              advance;
	logic              is_digit;
	logic [3:0]        digit;
	scan_t             nxt;

	function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
		input logic [3:0] d, input logic first);
		logic [10:0] wide;
		wide = (11'(acc) << 3) + (11'(acc) << 1) + 11'(d);
		return first ? NUM_W'(d) : wide[NUM_W-1:0];
	endfunction

	assign advance     = valid_s1 && !(final_s1 && out_busy);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1  <= chars.char_code;
			final_s1 <= chars.final_char;
		end
	end

	always_comb begin
		is_digit = char_s1 inside {[ZERO_CHAR:NINE_CHAR]};
		digit    = char_s1[3:0];

		nxt            = '0;
		nxt.item_valid = valid_s1;
		nxt.last       = final_s1;
		nxt.length_ok  = (pos_q == LAST_POS);
		nxt.err_seen   = err_seen_q;
		nxt.err_kind   = err_kind_q;
		nxt.err_index  = err_index_q;
		nxt.err_byte   = err_byte_q;
		nxt.year       = year_q;
		nxt.month      = month_q;
		nxt.day        = day_q;

		if (pos_q < DATE_LEN) begin
			if (pos_q == DASH_POS0 || pos_q == DASH_POS1) begin
				if (char_s1 != DASH_CHAR && !err_seen_q) begin
					nxt.err_seen  = 1'b1;
					nxt.err_kind  = ERR_DASH;
					nxt.err_index = pos_q;
					nxt.err_byte  = char_s1;
				end
			end else if (!is_digit) begin
				if (!err_seen_q) begin
					nxt.err_seen  = 1'b1;
					nxt.err_kind  = ERR_DIGIT;
					nxt.err_index = pos_q;
					nxt.err_byte  = char_s1;
				end
			end else begin
				case (pos_q)
					4'd2, 4'd3: nxt.year  = acc_digit(year_q, digit, pos_q == 4'd2);
					4'd5, 4'd6: nxt.month = acc_digit(month_q, digit, pos_q == 4'd5);
					4'd8, 4'd9: nxt.day   = acc_digit(day_q, digit, pos_q == 4'd8);
					default: ;
				endcase
			end
		end
	end

	assign scan = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			err_seen_q  <= 1'b0;
			err_kind_q  <= ERR_NONE;
			err_index_q <= '0;
			err_byte_q  <= '0;
			year_q      <= '0;
			month_q     <= '0;
			day_q       <= '0;
		end else if (advance) begin
			if (final_s1) begin
				pos_q       <= '0;
				err_seen_q  <= 1'b0;
				err_kind_q  <= ERR_NONE;
				err_index_q <= '0;
				err_byte_q  <= '0;
				year_q      <= '0;
				month_q     <= '0;
				day_q       <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 4'd1;
				end
				err_seen_q  <= nxt.err_seen;
				err_kind_q  <= nxt.err_kind;
				err_index_q <= nxt.err_index;
				err_byte_q  <= nxt.err_byte;
				year_q      <= nxt.year;
				month_q     <= nxt.month;
				day_q       <= nxt.day;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/dsv_verdict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_verdict
// Verdict logic for a final character and the result register.
// ----------------------------------------------------------------------------
module dsv_verdict
	import dsv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire scan_t   scan,
	output logic         out_busy,
	dsv_result_if.source verdicts
);

	logic               valid_q;
	logic               fire;
	logic               ok;
	error_kind_t        kind;
	logic [POS_W-1:0]   idx;
	logic [CHAR_W-1:0]  bad;
	logic [NUM_W-1:0]   num;
	logic [LIMIT_W-1:0] lim;
	logic [LIMIT_W-1:0] max_d;

	function automatic logic [LIMIT_W-1:0] max_day(input logic [NUM_W-1:0] m,
		input logic [NUM_W-1:0] y);
		logic [LIMIT_W-1:0] r;
		case (m)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                     r = 5'd30;
			7'd2:    r = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	assign out_busy = valid_q && !verdicts.ready;
	assign fire     = scan.item_valid && scan.last && !out_busy;

	always_comb begin
		max_d = max_day(scan.month, scan.year);
		ok    = 1'b0;
		kind  = ERR_NONE;
		idx   = '0;
		bad   = '0;
		num   = '0;
		lim   = '0;
		if (!scan.length_ok) begin
			kind = ERR_LENGTH;
		end else if (scan.err_seen) begin
			kind = scan.err_kind;
			idx  = scan.err_index;
			bad  = scan.err_byte;
		end else if (scan.month == 7'd0 || scan.month > 7'd12) begin
			kind = ERR_MONTH;
			num  = scan.month;
		end else begin
			lim = max_d;
			if (scan.day == 7'd0 || scan.day > NUM_W'(max_d)) begin
				kind = ERR_DAY;
				num  = scan.day;
			end else begin
				ok = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			verdicts.is_valid      <= ok;
			verdicts.error_kind    <= kind;
			verdicts.error_index   <= idx;
			verdicts.bad_character <= bad;
			verdicts.bad_number    <= num;
			verdicts.day_limit     <= lim;
		end
	end

	assign verdicts.valid = valid_q;

endmodule
`default_nettype wire

>>> design/date_string_validator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_string_validator_top
// Checks YYYY-MM-DD strings streamed one character per item and gives one
// verdict per string on its final character.
//
//   Channel    Dir   Payload
//   chars      in    char_code[7:0], final_char
//   verdicts   out   is_valid, error_kind[2:0], error_index[3:0],
//                    bad_character[7:0], bad_number[6:0], day_limit[4:0]
//
// One item per cycle while no final item waits on a held verdict. A verdict
// follows its final item through the input register, then the result register.
// Reset clears the scan state and both valid flags.
// Only a final item waits on a held verdict; other items keep flowing.
// ----------------------------------------------------------------------------
module date_string_validator_top
	import dsv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	dsv_char_if.sink     chars,
	dsv_result_if.source verdicts
);

	scan_t scan;
	logic  out_busy;

	dsv_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.out_busy (out_busy),
		.scan     (scan)
	);

	dsv_verdict u_verdict (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan),
		.out_busy (out_busy),
		.verdicts (verdicts)
	);

endmodule
`default_nettype wire
